@@ design/aes_pkg.sv @@
// Package: AES-128 constants, types and round functions.
`timescale 1ns / 1ps
package aes_pkg;
  localparam int NUM_ROUNDS = 10;
  localparam int KEY_WORDS = 4 * (NUM_ROUNDS + 1);
  localparam int KEY_ROW_W = $clog2(NUM_ROUNDS + 1);
  localparam int KEY_IDX_W = 6;
  localparam int RND_W = $clog2(NUM_ROUNDS + 1);
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ENCRYPT = 1'b1;

  typedef struct packed {
    logic         action;
    logic [5:0]   key_index;
    logic [31:0]  key_word;
    logic [127:0] block;
  } aes_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] b0, b1, b2, b3, a;
    b0 = w[7:0]; b1 = w[15:8]; b2 = w[23:16]; b3 = w[31:24];
    a = b0 ^ b1 ^ b2 ^ b3;
    mix_col = {b3 ^ a ^ xtime(b3 ^ b0), b2 ^ a ^ xtime(b2 ^ b3),
               b1 ^ a ^ xtime(b1 ^ b2), b0 ^ a ^ xtime(b0 ^ b1)};
  endfunction

  // SubBytes, ShiftRows and optional MixColumns; state column c at [32c+31:32c]
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[32*c+8*k +: 8] = SBOX[s[32*((c+k)%4)+8*k +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      r[32*c +: 32] = last ? t[32*c +: 32] : mix_col(t[32*c +: 32]);
    end
    round_fn = r;
  endfunction
endpackage

@@ design/aes_ram.sv @@
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module aes_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ design/aes_front.sv @@
// Front end: input queue of two entries holding accepted items.
`timescale 1ns / 1ps
module aes_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  aes_pkg::aes_item_t   in_item_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output aes_pkg::aes_item_t   q_item_o
);
  aes_pkg::aes_item_t buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, wr_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = buf_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_item_i;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("accept when full");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !q_valid_o) else $error("valid when empty");
endmodule

@@ design/aes_core.sv @@
// Back end: key store and iterative round unit with output register.
`timescale 1ns / 1ps
module aes_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  aes_pkg::aes_item_t  q_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [127:0]        out_data_o
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic st_q, st_d;
  logic [aes_pkg::RND_W-1:0] rnd_q, rnd_d;
  logic [1:0] col_q, col_d;
  logic [127:0] state_q, state_d, rk_q, rk_d;
  logic out_valid_q, out_valid_d;
  logic [127:0] out_q, out_d;
  logic key_we;
  logic [aes_pkg::KEY_ROW_W+1:0] raddr;
  logic [31:0] rdata;
  logic take;

  assign key_we = take && q_item_i.action == aes_pkg::ACT_LOAD &&
                  q_item_i.key_index < aes_pkg::KEY_IDX_W'(aes_pkg::KEY_WORDS);
  assign raddr = {rnd_d, col_d};

  aes_ram #(.Width(32), .Depth(aes_pkg::KEY_WORDS)) u_keys (
    .clk_i, .we_i(key_we), .waddr_i(q_item_i.key_index[aes_pkg::KEY_ROW_W+1:0]),
    .wdata_i(q_item_i.key_word), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign q_ready_o = (st_q == ST_IDLE) && !(out_valid_q && !out_ready_i);
  assign take = q_valid_i && q_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // Key words are read one per cycle into rk; a round applies when all four are in.
  always_comb begin
    st_d = st_q; rnd_d = rnd_q; col_d = col_q;
    state_d = state_q; rk_d = rk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    unique case (st_q)
      ST_IDLE: begin
        rnd_d = '0; col_d = '0;
        if (take && q_item_i.action == aes_pkg::ACT_ENCRYPT) begin
          state_d = q_item_i.block;
          st_d = ST_RUN;
        end
      end
      ST_RUN: begin
        rk_d[32*col_q +: 32] = rdata;
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) begin
          rnd_d = rnd_q + aes_pkg::RND_W'(1);
          if (rnd_q == '0) begin
            state_d = state_q ^ rk_d;
          end else if (rnd_q == aes_pkg::RND_W'(aes_pkg::NUM_ROUNDS)) begin
            out_d = aes_pkg::round_fn(state_q, 1'b1) ^ rk_d;
            out_valid_d = 1'b1;
            st_d = ST_IDLE;
            rnd_d = '0;
          end else begin
            state_d = aes_pkg::round_fn(state_q, 1'b0) ^ rk_d;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; rnd_q <= '0; col_q <= '0; out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d; rnd_q <= rnd_d; col_q <= col_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d; rk_q <= rk_d; out_q <= out_d;
  end

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_IDLE |-> !q_ready_o) else $error("accept while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q)) else $error("result lost");
  a_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q <= aes_pkg::RND_W'(aes_pkg::NUM_ROUNDS)) else $error("round overrun");
endmodule

@@ design/aes128_block_encrypt.sv @@
// Top level: AES-128 encryption over a loaded, pre-expanded key.
`timescale 1ns / 1ps
// Items pass a two-entry queue to an iterative core. A load writes one key word
// into the key RAM. An encrypt reads the 44 key words one per cycle from the key
// RAM read port and applies a round each time four words are in; the core takes
// no new item while it is busy with an encryption. The core takes a new item
// only while the output register is empty or being read, so a stalled result
// holds the core and the queue fills behind it.
module aes128_block_encrypt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,  // key_index, key_word, block_low, block_high
  input  logic         s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // cipher_low, cipher_high
);
  aes_pkg::aes_item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item.action = s_axis_tuser;
  assign in_item.key_index = s_axis_tdata[5:0];
  assign in_item.key_word = s_axis_tdata[37:6];
  assign in_item.block = s_axis_tdata[165:38];

  aes_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_item_i(in_item), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  aes_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );
endmodule
